/* hw/rtl/swbc_pkg.sv */
// shared definitions for the stack with bidirectional cursor
// action codes and the command/status bundles between controller and datapath
// no dependencies
package swbc_pkg;

  localparam int ACTION_W = 3;

  localparam logic [ACTION_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_MOVE    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REWIND  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SET_DIR = 3'd5;

  typedef struct packed {
    logic accept;     // request transfer this cycle
    logic load_read;  // capture memory read data into the result register
  } swbc_cmd_t;

  typedef struct packed {
    logic read_needed;  // the offered action returns a stored word
  } swbc_stat_t;

endpackage

/* hw/rtl/swbc_if.sv */
// request and response channel interfaces of the stack block
// depends on swbc_pkg for the action width
interface swbc_req_if #(
  parameter int WORD_WIDTH = 32
);
  import swbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [WORD_WIDTH-1:0] push_word;
  logic                  new_direction;

  modport source (output valid, output action, output push_word, output new_direction,
                  input ready);
  modport sink   (input valid, input action, input push_word, input new_direction,
                  output ready);
endinterface

interface swbc_rsp_if #(
  parameter int WORD_WIDTH = 32,
  parameter int IDX_W      = 8,
  parameter int CNT_W      = 9
);
  logic                  valid;
  logic                  ready;
  logic                  word_valid;
  logic [WORD_WIDTH-1:0] word_out;
  logic [IDX_W-1:0]      push_index;
  logic                  overflow;
  logic [CNT_W-1:0]      element_count;

  modport source (output valid, output word_valid, output word_out, output push_index,
                  output overflow, output element_count, input ready);
  modport sink   (input valid, input word_valid, input word_out, input push_index,
                  input overflow, input element_count, output ready);
endinterface

/* hw/rtl/swbc_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
module swbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/swbc_ctrl.sv */
// controller: accept handshake, read wait state and result valid flag
// depends on swbc_pkg
module swbc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  swbc_pkg::swbc_stat_t stat,
  output swbc_pkg::swbc_cmd_t  cmd
);
  import swbc_pkg::*;

  localparam logic [0:0] IDLE = 1'b0;
  localparam logic [0:0] READ = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       rsp_valid_next;

  // a new request may come in when idle and the result slot is empty or being drained
  assign req_ready     = (state == IDLE) && (!rsp_valid || rsp_ready);
  assign cmd.accept    = req_valid && req_ready;
  assign cmd.load_read = (state == READ);

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid;
    unique case (state)
      IDLE: begin
        if (cmd.accept) begin
          state_next     = stat.read_needed ? READ : IDLE;
          rsp_valid_next = !stat.read_needed;
        end else if (rsp_ready) begin
          rsp_valid_next = 1'b0;
        end
      end
      READ: begin
        // slot is always free here: it was empty or drained at accept
        state_next     = IDLE;
        rsp_valid_next = 1'b1;
      end
      default: begin
        state_next     = IDLE;
        rsp_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

/* hw/rtl/swbc_dp.sv */
// datapath: element store, count, cursor, direction and result register
// depends on swbc_pkg and swbc_ram
module swbc_dp #(
  parameter int CAPACITY   = 256,
  parameter int WORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [swbc_pkg::ACTION_W-1:0]      action,
  input  logic [WORD_WIDTH-1:0]              push_word,
  input  logic                               new_direction,
  input  swbc_pkg::swbc_cmd_t                cmd,
  output swbc_pkg::swbc_stat_t               stat,
  output logic                               word_valid,
  output logic [WORD_WIDTH-1:0]              word_out,
  output logic [$clog2(CAPACITY)-1:0]        push_index,
  output logic                               overflow,
  output logic [$clog2(CAPACITY+1)-1:0]      element_count
);
  import swbc_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = CW + 1;

  localparam logic signed [KW-1:0] MINUS_ONE = KW'(-1);
  localparam logic signed [KW-1:0] ZERO      = KW'(0);
  localparam logic signed [KW-1:0] ONE       = KW'(1);
  localparam logic [CW-1:0]        FULL      = CW'(CAPACITY);

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic signed [KW-1:0] cursor;
  logic signed [KW-1:0] cursor_next;
  logic                 walk_backward;
  logic                 walk_backward_next;
  logic signed [KW-1:0] count_s;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [WORD_WIDTH-1:0] rdata;
  logic [AW-1:0]         pidx_next;
  logic                  ovf_next;

  assign count_s       = $signed({1'b0, count});
  assign element_count = count;

  always_comb begin
    count_next         = count;
    cursor_next        = cursor;
    walk_backward_next = walk_backward;
    we                 = 1'b0;
    waddr              = count[AW-1:0];
    re                 = 1'b0;
    raddr              = '0;
    pidx_next          = '0;
    ovf_next           = 1'b0;
    stat.read_needed   = 1'b0;
    unique case (action)
      ACT_PUSH: begin
        if (count == FULL) begin
          ovf_next = 1'b1;
        end else begin
          we         = 1'b1;
          pidx_next  = count[AW-1:0];
          count_next = count + CW'(1);
          // first word after empty places the cursor at the walking end
          if (count == '0) begin
            cursor_next = walk_backward ? ONE : MINUS_ONE;
          end
        end
      end
      ACT_POP: begin
        if (count != '0) begin
          count_next       = count - CW'(1);
          re               = 1'b1;
          raddr            = count_next[AW-1:0];
          stat.read_needed = 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_next  = '0;
        cursor_next = ZERO;
      end
      ACT_MOVE: begin
        if (count != '0) begin
          if (!walk_backward) begin
            if (cursor < count_s - ONE) begin
              cursor_next      = cursor + ONE;
              re               = 1'b1;
              raddr            = cursor_next[AW-1:0];
              stat.read_needed = 1'b1;
            end
          end else if (cursor > ZERO) begin
            cursor_next      = cursor - ONE;
            re               = 1'b1;
            raddr            = cursor_next[AW-1:0];
            stat.read_needed = 1'b1;
          end
        end
      end
      ACT_REWIND: begin
        cursor_next = walk_backward ? count_s : MINUS_ONE;
      end
      ACT_SET_DIR: begin
        walk_backward_next = new_direction;
        // a cursor parked at one end jumps to the other end
        if (count != '0) begin
          if (cursor == MINUS_ONE) begin
            cursor_next = count_s;
          end else if (cursor == count_s) begin
            cursor_next = MINUS_ONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  swbc_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we && cmd.accept),
    .waddr (waddr),
    .wdata (push_word),
    .re    (re && cmd.accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      cursor        <= ZERO;
      walk_backward <= 1'b1;
    end else if (cmd.accept) begin
      count         <= count_next;
      cursor        <= cursor_next;
      walk_backward <= walk_backward_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_valid <= 1'b0;
      word_out   <= '0;
      push_index <= pidx_next;
      overflow   <= ovf_next;
    end else if (cmd.load_read) begin
      word_valid <= 1'b1;
      word_out   <= rdata;
    end
  end

endmodule

/* hw/rtl/stack_with_bidirectional_cursor.sv */
// stack of data words with a bidirectional cursor over the stored entries
// push, clear, rewind, set direction, and pop or move with no word: result valid in the cycle after the transfer
// pop and move with data: result valid after the READ wait state for the registered store read
// one request in flight; a new request is taken as the result drains
// synchronous reset: count 0, cursor 0, backward walk; store contents undefined
// depends on swbc_pkg, swbc_if, swbc_ctrl, swbc_dp, swbc_ram
module stack_with_bidirectional_cursor #(
  parameter int CAPACITY   = 256,
  parameter int WORD_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  swbc_req_if.sink  req,
  swbc_rsp_if.source rsp
);
  import swbc_pkg::*;

  swbc_cmd_t  cmd;
  swbc_stat_t stat;

  swbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swbc_dp #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (req.action),
    .push_word     (req.push_word),
    .new_direction (req.new_direction),
    .cmd           (cmd),
    .stat          (stat),
    .word_valid    (rsp.word_valid),
    .word_out      (rsp.word_out),
    .push_index    (rsp.push_index),
    .overflow      (rsp.overflow),
    .element_count (rsp.element_count)
  );

endmodule

/* hw/rtl/swbc_checker.sv */
// port-level checks for the stack block, attached by bind to the top level
// depends only on the top-level ports
module swbc_checker #(
  parameter int CAPACITY   = 256,
  parameter int WORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          word_valid,
  input logic [WORD_WIDTH-1:0]         word_out,
  input logic [$clog2(CAPACITY)-1:0]   push_index,
  input logic                          overflow,
  input logic [$clog2(CAPACITY+1)-1:0] element_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && overflow |-> element_count == CW'(CAPACITY))
    else $error("overflow reported with store not full");

  a_word_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && word_valid |-> !overflow && push_index == '0)
    else $error("returned word mixed with push fields");

  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !word_valid |-> word_out == '0)
    else $error("word output nonzero without returned word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(word_out) && $stable(element_count))
    else $error("stalled result changed");

endmodule

bind stack_with_bidirectional_cursor swbc_checker #(
  .CAPACITY   (CAPACITY),
  .WORD_WIDTH (WORD_WIDTH)
) u_swbc_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .word_valid    (rsp.word_valid),
  .word_out      (rsp.word_out),
  .push_index    (rsp.push_index),
  .overflow      (rsp.overflow),
  .element_count (rsp.element_count)
);
